[rtl/pscb_pkg.sv]
// ----------------------------------------------------------------------------
// pscb_pkg
// Types and constants shared by the palette scaler with blending.
// ----------------------------------------------------------------------------
package pscb_pkg;

   // operation codes of a request transfer
   localparam logic [2:0] OP_PAL_WRITE  = 3'd0;
   localparam logic [2:0] OP_CMAP_WRITE = 3'd1;
   localparam logic [2:0] OP_RMAP_WRITE = 3'd2;
   localparam logic [2:0] OP_SRC_WRITE  = 3'd3;
   localparam logic [2:0] OP_RENDER     = 3'd4;

   // configuration register indexes
   localparam logic [1:0] CSR_OUT_WIDTH    = 2'd0;
   localparam logic [1:0] CSR_OUT_HEIGHT   = 2'd1;
   localparam logic [1:0] CSR_BLEND_ENABLE = 2'd2;

   localparam int          CSR_DATA_W        = 9;
   localparam logic [8:0]  OUT_WIDTH_RESET   = 9'd256;
   localparam logic [8:0]  OUT_HEIGHT_RESET  = 9'd240;
   localparam logic        BLEND_RESET       = 1'b1;

   localparam int          PAL_DEPTH         = 256;
   localparam int          SRC_DEPTH         = 65536;
   // one source row is 256 bytes: the row index is the upper address byte
   localparam logic [15:0] SRC_STRIDE        = 16'd256;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] entry_index;
      logic [15:0] entry_value;
      logic [7:0]  dest_x;
      logic [7:0]  dest_y;
   } req_type;

   typedef struct packed {
      logic [15:0] pixel;
      logic [7:0]  out_x;
      logic [7:0]  out_y;
      logic        status;
   } rsp_type;

   // per-render tag carried down the pipeline
   typedef struct packed {
      logic [7:0] x;
      logic [7:0] y;
      logic       oor;
   } tag_type;

endpackage

[rtl/palette_scaler_with_blend.sv]
// ----------------------------------------------------------------------------
// palette_scaler_with_blend
// Nearest-pixel scaler from a palette-indexed 256-wide source to RGB565.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: raise start with req_data; the transfer happens at a
//   rising edge where start is high and busy is low. Ops 0..3 load the
//   palette, column map, row map or source image; op 4 renders one pixel.
//   Result channel: rsp_valid strobes for one cycle with rsp_data (pixel,
//   coordinates, status). There is no back-pressure: take it that cycle.
//   CSR port: csr_we, csr_index, csr_wdata write out_width, out_height or
//   blend_enable, one register per write. Write only while no render is in flight.
// Timing:
//   Loads may follow each other every cycle while busy is low.
//   A render holds busy while it is in stages v1 and v2, so the next
//   transfer can land as it moves on to v4. The lower neighbour's palette
//   color is read as v4 is set; busy keeps any later load from landing
//   in a table before the last read of the render ahead of it.
//   The result strobe is registered from v4.
// Reset:
//   Clears the pipeline and loads register defaults (256, 240, blend on).
//   Table contents are undefined until loaded; there is no clearing pass.
// ----------------------------------------------------------------------------
module palette_scaler_with_blend #(
   parameter int MAX_DEST_WIDTH  = 256,
   parameter int MAX_DEST_HEIGHT = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  pscb_pkg::req_type                req_data,
   output logic                             rsp_valid,
   output pscb_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [1:0]                       csr_index,
   input  logic [pscb_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pscb_pkg::*;

   localparam int CM_DEPTH = MAX_DEST_WIDTH + 1;
   localparam int RM_DEPTH = MAX_DEST_HEIGHT + 1;
   localparam int CM_AW    = $clog2(CM_DEPTH);
   localparam int RM_AW    = $clog2(RM_DEPTH);

   // ---------------------------------------------------------------- CSRs
   logic [8:0] out_width_ff,  out_width_in;
   logic [8:0] out_height_ff, out_height_in;
   logic       blend_ff,      blend_in;

   always_comb begin
      out_width_in  = out_width_ff;
      out_height_in = out_height_ff;
      blend_in      = blend_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_OUT_WIDTH:    out_width_in  = csr_wdata;
            CSR_OUT_HEIGHT:   out_height_in = csr_wdata;
            CSR_BLEND_ENABLE: blend_in      = csr_wdata[0];
            default: ;        // unknown index: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_width_ff  <= OUT_WIDTH_RESET;
         out_height_ff <= OUT_HEIGHT_RESET;
         blend_ff      <= BLEND_RESET;
      end else begin
         out_width_ff  <= out_width_in;
         out_height_ff <= out_height_in;
         blend_ff      <= blend_in;
      end
   end

   // ------------------------------------------------------- request decode
   logic accept;
   logic do_render, do_pal, do_cmap, do_rmap, do_src;

   assign accept    = start && !busy;
   assign do_render = accept && (req_data.op == OP_RENDER);
   assign do_pal    = accept && (req_data.op == OP_PAL_WRITE)
                      && (req_data.entry_index < 16'(PAL_DEPTH));
   assign do_cmap   = accept && (req_data.op == OP_CMAP_WRITE)
                      && (req_data.entry_index < 16'(CM_DEPTH));
   assign do_rmap   = accept && (req_data.op == OP_RMAP_WRITE)
                      && (req_data.entry_index < 16'(RM_DEPTH));
   assign do_src    = accept && (req_data.op == OP_SRC_WRITE);

   // --------------------------------------------------------------- stages
   // v1: map data ready, v2: source pair ready, v3: first palette pair
   // ready, v4: last palette color ready.
   logic    v1_ff, v2_ff, v3_ff, v4_ff;
   logic    v1_in, v2_in, v3_in, v4_in;
   tag_type t1_ff, t2_ff, t3_ff, t4_ff;
   tag_type t1_in;
   logic    dx2_ff, dx3_ff, dx4_ff, dy2_ff, dy3_ff, dy4_ff;
   logic    dx2_in, dy2_in;

   // a new transfer may land once the previous render has left the map
   // and both source stages; later reads never meet a newer write
   assign busy = v1_ff || v2_ff;

   assign v1_in = do_render;
   assign v2_in = v1_ff;
   assign v3_in = v2_ff;
   assign v4_in = v3_ff;

   always_comb begin
      t1_in.x   = req_data.dest_x;
      t1_in.y   = req_data.dest_y;
      t1_in.oor = ({1'b0, req_data.dest_x} >= out_width_ff)
               || ({1'b0, req_data.dest_y} >= out_height_ff)
               || ({1'b0, req_data.dest_x} >= 9'(MAX_DEST_WIDTH))
               || ({1'b0, req_data.dest_y} >= 9'(MAX_DEST_HEIGHT));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      t1_ff  <= t1_in;
      t2_ff  <= t1_ff;
      t3_ff  <= t2_ff;
      t4_ff  <= t3_ff;
      dx2_ff <= dx2_in;
      dy2_ff <= dy2_in;
      dx3_ff <= dx2_ff;
      dy3_ff <= dy2_ff;
      dx4_ff <= dx3_ff;
      dy4_ff <= dy3_ff;
   end

   // ----------------------------------------------------------- map memories
   // Each map reads the entry of the coordinate and the next one.
   logic [7:0] cmap_mem [CM_DEPTH];
   logic [7:0] rmap_mem [RM_DEPTH];
   logic [7:0] cm0_ff, cm1_ff, rm0_ff, rm1_ff;
   logic [8:0] x_cur, y_cur, x_next, y_next;
   logic [CM_AW-1:0] cm_ra0, cm_ra1;
   logic [RM_AW-1:0] rm_ra0, rm_ra1;

   assign x_cur  = {1'b0, req_data.dest_x};
   assign y_cur  = {1'b0, req_data.dest_y};
   assign x_next = x_cur + 9'd1;
   assign y_next = y_cur + 9'd1;
   assign cm_ra0 = x_cur[CM_AW-1:0];
   assign cm_ra1 = x_next[CM_AW-1:0];
   assign rm_ra0 = y_cur[RM_AW-1:0];
   assign rm_ra1 = y_next[RM_AW-1:0];

   always_ff @(posedge clock) begin
      if (do_cmap) begin
         cmap_mem[req_data.entry_index[CM_AW-1:0]] <= req_data.entry_value[7:0];
      end
      cm0_ff <= cmap_mem[cm_ra0];
      cm1_ff <= cmap_mem[cm_ra1];
   end

   always_ff @(posedge clock) begin
      if (do_rmap) begin
         rmap_mem[req_data.entry_index[RM_AW-1:0]] <= req_data.entry_value[7:0];
      end
      rm0_ff <= rmap_mem[rm_ra0];
      rm1_ff <= rmap_mem[rm_ra1];
   end

   // ------------------------------------------------------- source memory
   // Stage 1 fetches the pixel and its right neighbour, stage 2 the pixel
   // below, on port A again.
   logic [7:0]  src_mem [SRC_DEPTH];
   logic [7:0]  src_rd_a_ff, src_rd_b_ff;
   logic [15:0] addr0, addr1, src_ra;
   logic [15:0] addr2_ff, addr2_in;

   assign addr0    = {rm0_ff, cm0_ff};
   assign addr1    = addr0 + 16'd1;         // wraps at 16 bits
   assign addr2_in = addr0 + SRC_STRIDE;    // wraps at 16 bits
   assign dx2_in   = blend_ff && (cm1_ff != cm0_ff);
   assign dy2_in   = blend_ff && (rm1_ff != rm0_ff);
   assign src_ra   = v2_ff ? addr2_ff : addr0;

   always_ff @(posedge clock) begin
      addr2_ff <= addr2_in;
   end

   always_ff @(posedge clock) begin
      if (do_src) begin
         src_mem[req_data.entry_index] <= req_data.entry_value[7:0];
      end
      src_rd_a_ff <= src_mem[src_ra];
      src_rd_b_ff <= src_mem[addr1];
   end

   // ------------------------------------------------------ palette memory
   // Port A sees the pixel color in stage 2 and the lower color in stage 3;
   // port B sees the right neighbour color in stage 2.
   logic [15:0] pal_mem [PAL_DEPTH];
   logic [15:0] pal_rd_a_ff, pal_rd_b_ff;
   logic [15:0] p0_ff, p1_ff;

   always_ff @(posedge clock) begin
      if (do_pal) begin
         pal_mem[req_data.entry_index[7:0]] <= req_data.entry_value;
      end
      pal_rd_a_ff <= pal_mem[src_rd_a_ff];
      pal_rd_b_ff <= pal_mem[src_rd_b_ff];
   end

   // hold the first pair while port A fetches the lower color
   always_ff @(posedge clock) begin
      p0_ff <= pal_rd_a_ff;
      p1_ff <= pal_rd_b_ff;
   end

   // --------------------------------------------------------------- blend
   // halve each channel of both colors and add; no channel can carry out
   function automatic logic [15:0] blend_avg(input logic [15:0] a, input logic [15:0] b);
      logic [4:0] r;
      logic [5:0] g;
      logic [4:0] bl;
      r  = {1'b0, a[15:12]} + {1'b0, b[15:12]};
      g  = {1'b0, a[10:6]}  + {1'b0, b[10:6]};
      bl = {1'b0, a[4:1]}   + {1'b0, b[4:1]};
      return {r, g, bl};
   endfunction

   logic [15:0] c_right, c_below;

   assign c_right = dx4_ff ? blend_avg(p0_ff, p1_ff) : p0_ff;
   assign c_below = dy4_ff ? blend_avg(c_right, pal_rd_a_ff) : c_right;

   // -------------------------------------------------------------- result
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff,  rsp_data_in;

   assign rsp_valid_in = v4_ff;

   always_comb begin
      rsp_data_in.out_x  = t4_ff.x;
      rsp_data_in.out_y  = t4_ff.y;
      rsp_data_in.status = t4_ff.oor;
      rsp_data_in.pixel  = t4_ff.oor ? 16'd0 : c_below;   // zero out of range
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the palette scaler with neighbour blending.
// Loads the palette, column and row maps and the source image, renders pixels
// under several size and blend settings, and checks every pixel against a
// predictor that follows the tables as they are loaded.
// ----------------------------------------------------------------------------
module testbench;
   import pscb_pkg::*;

   // cycles without any transfer before the run is declared hung
   localparam int WATCHDOG_LIMIT = 200;
   // margin after the last result before CSR writes
   localparam int SETTLE_CYCLES  = 8;
   // counted load and render transfers per configuration phase
   localparam int PHASE_ITEMS    = 85;
   localparam int NUM_PHASES     = 9;
   localparam int MAP_DEPTH      = 257;
   // no register lives at this index; writes to it must be dropped
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   // -------------------------------------------------------------------------
   // Scoreboard: shadow tables and registers, expected pixel queue.
   // -------------------------------------------------------------------------
   class scaler_scoreboard;
      logic [15:0]         palette     [PAL_DEPTH];
      logic [7:0]          col_map     [MAP_DEPTH];
      logic [7:0]          row_map     [MAP_DEPTH];
      logic [7:0]          src_img     [SRC_DEPTH];
      // entries the block has been given; renders only touch these
      bit                  pal_loaded  [PAL_DEPTH];
      bit                  col_loaded  [MAP_DEPTH];
      bit                  row_loaded  [MAP_DEPTH];
      bit                  src_loaded  [SRC_DEPTH];
      logic [8:0]          width;
      logic [8:0]          height;
      logic                blend_on;
      rsp_type             pending_pixels[$];
      int                  mismatches;

      function new();
         width      = OUT_WIDTH_RESET;
         height     = OUT_HEIGHT_RESET;
         blend_on   = BLEND_RESET;
         mismatches = 0;
      endfunction

      function void write_reg(input logic [1:0] index, input logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_OUT_WIDTH:    width    = data;
            CSR_OUT_HEIGHT:   height   = data;
            CSR_BLEND_ENABLE: blend_on = data[0];
            default: ;
         endcase
      endfunction

      // halve each channel of both colors and add them
      function logic [15:0] half_sum(input logic [15:0] a, input logic [15:0] b);
         logic [4:0] red;
         logic [5:0] green;
         logic [4:0] blue;
         red   = 5'(a[15:12]) + 5'(b[15:12]);
         green = 6'(a[10:6]) + 6'(b[10:6]);
         blue  = 5'(a[4:1]) + 5'(b[4:1]);
         return {red, green, blue};
      endfunction

      function logic [15:0] color_at(input logic [15:0] addr);
         return palette[src_img[addr]];
      endfunction

      function void note_transfer(input req_type item);
         rsp_type     want;
         logic [15:0] base;
         logic [8:0]  xi;
         logic [8:0]  yi;
         xi = {1'b0, item.dest_x};
         yi = {1'b0, item.dest_y};
         case (item.op)
            OP_PAL_WRITE: if (item.entry_index < PAL_DEPTH) begin
               palette[item.entry_index[7:0]]    = item.entry_value;
               pal_loaded[item.entry_index[7:0]] = 1'b1;
            end
            OP_CMAP_WRITE: if (item.entry_index < MAP_DEPTH) begin
               col_map[item.entry_index[8:0]]    = item.entry_value[7:0];
               col_loaded[item.entry_index[8:0]] = 1'b1;
            end
            OP_RMAP_WRITE: if (item.entry_index < MAP_DEPTH) begin
               row_map[item.entry_index[8:0]]    = item.entry_value[7:0];
               row_loaded[item.entry_index[8:0]] = 1'b1;
            end
            OP_SRC_WRITE: begin
               src_img[item.entry_index]    = item.entry_value[7:0];
               src_loaded[item.entry_index] = 1'b1;
            end
            OP_RENDER: begin
               want.out_x = item.dest_x;
               want.out_y = item.dest_y;
               if (item.dest_x >= width || item.dest_y >= height) begin
                  want.pixel  = 16'd0;
                  want.status = 1'b1;
               end else begin
                  base       = {row_map[yi], col_map[xi]};
                  want.pixel = color_at(base);
                  if (blend_on) begin
                     // addresses wrap at 16 bits through the argument width
                     if (col_map[xi + 9'd1] != col_map[xi])
                        want.pixel = half_sum(want.pixel, color_at(base + 16'd1));
                     if (row_map[yi + 9'd1] != row_map[yi])
                        want.pixel = half_sum(want.pixel, color_at(base + SRC_STRIDE));
                  end
                  want.status = 1'b0;
               end
               pending_pixels.push_back(want);
            end
            default: ;
         endcase
      endfunction

      function void compare_field(input string name, input logic [15:0] want,
                                  input logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_pixel(input rsp_type got);
         rsp_type want;
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            mismatches++;
            return;
         end
         want = pending_pixels.pop_front();
         compare_field("pixel",  want.pixel,        got.pixel);
         compare_field("out_x",  16'(want.out_x),   16'(got.out_x));
         compare_field("out_y",  16'(want.out_y),   16'(got.out_y));
         compare_field("status", 16'(want.status),  16'(got.status));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block under test and its stimulus signals
   // -------------------------------------------------------------------------
   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   req_type                 req_data;
   logic                    rsp_valid;
   rsp_type                 rsp_data;
   logic                    csr_we;
   logic [1:0]              csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   scaler_scoreboard        pixel_board;
   int                      idle_percent = 0;
   int                      items_sent   = 0;
   int                      quiet_cycles = 0;

   palette_scaler_with_blend i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // The result channel has no back-pressure: take every strobed pixel.
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         pixel_board.check_pixel(rsp_data);
   end

   // Count cycles in which nothing moves on any port; give up at the limit.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("testbench NOT OK");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // Drive one request, after idle cycles drawn one at a time at the phase's
   // idle rate, and hold it until the block takes the transfer. Start stays
   // high across back-to-back items.
   task automatic send_item(input req_type item);
      int          gap;
      logic [63:0] noise;
      gap = 0;
      while ($urandom_range(0, 99) < idle_percent)
         gap++;
      @(negedge clock);
      if (gap > 0) begin
         // drop start and put junk on the bus: the block must ignore it
         noise    = {$urandom, $urandom};
         start    = 1'b0;
         req_data = noise[$bits(req_type)-1:0];
         repeat (gap) @(negedge clock);
      end
      start    = 1'b1;
      req_data = item;
      @(posedge clock);
      while (busy) @(posedge clock);
      pixel_board.note_transfer(item);
      if (item.op <= OP_RENDER)
         items_sent++;
   endtask

   task automatic load_entry(input logic [2:0] op, input logic [15:0] index,
                             input logic [15:0] value);
      req_type item;
      item.op          = op;
      item.entry_index = index;
      item.entry_value = value;
      item.dest_x      = 8'($urandom);
      item.dest_y      = 8'($urandom);
      send_item(item);
   endtask

   // Half the time give a neighbour map entry the same coordinate, so that
   // blending along that axis is skipped.
   function automatic logic [15:0] neighbor_value(input logic [7:0] here);
      if ($urandom_range(0, 1) == 1)
         return {8'($urandom), here};
      return 16'($urandom);
   endfunction

   // Load a source byte and its palette color unless the block has them.
   task automatic fill_source(input logic [15:0] addr);
      if (!pixel_board.src_loaded[addr])
         load_entry(OP_SRC_WRITE, addr, 16'($urandom));
      if (!pixel_board.pal_loaded[pixel_board.src_img[addr]])
         load_entry(OP_PAL_WRITE, 16'(pixel_board.src_img[addr]), 16'($urandom));
   endtask

   // Render one pixel. Load first every map entry, source byte and palette
   // color that it may touch, neighbours included, whatever the blend setting
   // or range check: tables are undefined until written.
   task automatic render_pixel(input logic [7:0] x, input logic [7:0] y);
      req_type     item;
      logic [15:0] base;
      logic [8:0]  xi;
      logic [8:0]  yi;
      xi = {1'b0, x};
      yi = {1'b0, y};
      if (!pixel_board.col_loaded[xi])
         load_entry(OP_CMAP_WRITE, 16'(x), 16'($urandom));
      if (!pixel_board.col_loaded[xi + 9'd1])
         load_entry(OP_CMAP_WRITE, 16'(x) + 16'd1, neighbor_value(pixel_board.col_map[xi]));
      if (!pixel_board.row_loaded[yi])
         load_entry(OP_RMAP_WRITE, 16'(y), 16'($urandom));
      if (!pixel_board.row_loaded[yi + 9'd1])
         load_entry(OP_RMAP_WRITE, 16'(y) + 16'd1, neighbor_value(pixel_board.row_map[yi]));
      base = {pixel_board.row_map[yi], pixel_board.col_map[xi]};
      fill_source(base);
      fill_source(base + 16'd1);
      fill_source(base + SRC_STRIDE);
      item.op          = OP_RENDER;
      item.entry_index = 16'($urandom);
      item.entry_value = 16'($urandom);
      item.dest_x      = x;
      item.dest_y      = y;
      send_item(item);
   endtask

   // Unknown ops: random fields, no result expected.
   task automatic skip_item();
      req_type item;
      item.op          = 3'($urandom_range(5, 7));
      item.entry_index = 16'($urandom);
      item.entry_value = 16'($urandom);
      item.dest_x      = 8'($urandom);
      item.dest_y      = 8'($urandom);
      send_item(item);
   endtask

   // Random table write; source indexes and a quarter of the others span all
   // 16 bits, so many palette and map writes land out of range and must be dropped.
   task automatic random_write();
      logic [2:0]  op;
      logic [15:0] index;
      op = 3'($urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0 || op == OP_SRC_WRITE)
         index = 16'($urandom);
      else if (op == OP_PAL_WRITE)
         index = 16'($urandom_range(0, PAL_DEPTH - 1));
      else
         index = 16'($urandom_range(0, MAP_DEPTH - 1));
      load_entry(op, index, 16'($urandom));
   endtask

   // Mostly in-range coordinates, the rest over the full field.
   function automatic logic [7:0] pick_coord(input int limit);
      int span;
      span = (limit > 256) ? 256 : limit;
      if (span > 0 && $urandom_range(0, 9) < 7)
         return 8'($urandom_range(0, span - 1));
      return 8'($urandom);
   endfunction

   task automatic run_random(input int count);
      int stop_at;
      int pick;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 45)
            render_pixel(pick_coord(pixel_board.width), pick_coord(pixel_board.height));
         else if (pick < 90)
            random_write();
         else
            skip_item();
      end
   endtask

   // Edges of the tables and registers at their reset values (240 rows).
   task automatic run_directed();
      // column 0/1 share a coordinate, rows 0/1 differ: vertical blend only;
      // upper value bits of map writes are dropped
      load_entry(OP_CMAP_WRITE, 16'd0,   16'd0);
      load_entry(OP_CMAP_WRITE, 16'd1,   16'hFF00);
      load_entry(OP_RMAP_WRITE, 16'd0,   16'd0);
      load_entry(OP_RMAP_WRITE, 16'd1,   16'd1);
      // last column and last row in use point at source 255/255 with the
      // next entries at 0: both neighbour addresses wrap
      load_entry(OP_CMAP_WRITE, 16'd255, 16'hFFFF);
      load_entry(OP_CMAP_WRITE, 16'd256, 16'd0);
      load_entry(OP_RMAP_WRITE, 16'd239, 16'd255);
      load_entry(OP_RMAP_WRITE, 16'd240, 16'd0);
      // full white and black so averages hit the channel maxima
      load_entry(OP_PAL_WRITE,  16'd0,   16'hFFFF);
      load_entry(OP_PAL_WRITE,  16'd255, 16'hFFFF);
      load_entry(OP_PAL_WRITE,  16'd1,   16'h0000);
      load_entry(OP_SRC_WRITE,  16'h0000, 16'h0000);
      load_entry(OP_SRC_WRITE,  16'h0001, 16'h5A01);
      load_entry(OP_SRC_WRITE,  16'h0100, 16'h00FF);
      load_entry(OP_SRC_WRITE,  16'hFFFF, 16'hA501);
      load_entry(OP_SRC_WRITE,  16'h00FF, 16'hFFFF);
      // writes past the table ends and an unknown op: all dropped
      load_entry(OP_PAL_WRITE,  16'h0100, 16'h1234);
      load_entry(OP_CMAP_WRITE, 16'hFFFF, 16'h00AA);
      load_entry(OP_RMAP_WRITE, 16'd257,  16'h0055);
      skip_item();
      render_pixel(8'd0,   8'd0);
      render_pixel(8'd255, 8'd239);
      // rows 240 and up lie outside the reset height
      render_pixel(8'd0,   8'd240);
      render_pixel(8'd255, 8'd255);
   endtask

   // -------------------------------------------------------------------------
   // Configuration side
   // -------------------------------------------------------------------------

   // Drop start, wait for every pending pixel, then give the pipeline time
   // to finish any load still in flight.
   task automatic settle();
      @(negedge clock);
      start = 1'b0;
      while (pixel_board.pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(posedge clock);
      pixel_board.write_reg(index, data);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic configure(input logic [8:0] width, input logic [8:0] height,
                            input logic [8:0] blend_word);
      write_csr(CSR_OUT_WIDTH,    width);
      write_csr(CSR_OUT_HEIGHT,   height);
      write_csr(CSR_BLEND_ENABLE, blend_word);
   endtask

   // -------------------------------------------------------------------------
   // Main sequence: reset, directed edges, then one random phase per setting
   // -------------------------------------------------------------------------
   initial begin
      pixel_board = new();
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0)
            settle();
         // some blend words carry random upper bits: only bit 0 counts
         case (phase)
            0: idle_percent = 0;
            1: begin
               configure(9'd256, 9'd256, 9'd0);
               idle_percent = 62;
            end
            2: begin
               configure(9'd1, 9'd1, 9'd1);
               idle_percent = 0;
            end
            3: begin
               // zero width: every render comes back flagged
               configure(9'd0, 9'd256, {8'($urandom), 1'b1});
               idle_percent = 19;
            end
            4: begin
               configure(9'd256, 9'd0, {8'($urandom), 1'b0});
               idle_percent = 62;
            end
            5: begin
               configure(9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)),
                         9'($urandom));
               idle_percent = 0;
            end
            6: begin
               // widest register values; then a write to a missing register
               configure(9'h1FF, 9'h1FF, 9'h1FF);
               write_csr(CSR_UNUSED, 9'($urandom));
               idle_percent = 19;
            end
            7: begin
               configure(9'($urandom), 9'($urandom), 9'($urandom));
               idle_percent = 62;
            end
            default: begin
               configure(9'd256, 9'd256, 9'd1);
               idle_percent = 19;
            end
         endcase
         if (phase == 0) begin
            run_directed();
            run_random(PHASE_ITEMS - 25);
         end else begin
            run_random(PHASE_ITEMS);
         end
      end

      settle();
      if (pixel_board.mismatches == 0 && pixel_board.pending_pixels.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

[filelist.f]
rtl/pscb_pkg.sv
rtl/palette_scaler_with_blend.sv
test/testbench.sv
